// ----- rtl/core/mmfe_pkg.sv -----
// ============================================================================
// mmfe_pkg : shared types, constants and CRC helper
// Types, frame constants and the bytewise CRC-16 step shared by the
// front end, job queue, back end and top level of the meter frame engine.
// ============================================================================
`default_nettype none

package mmfe_pkg;

    // Response framing
    localparam int MAX_FRAME = 40;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 6;
    localparam int PAY_FIRST = 3;
    localparam int PAY_BYTES = 24;
    localparam int NUM_WORDS = 6;

    // Request framing
    localparam int REQ_LEN   = 8;
    localparam int IDX_W     = $clog2(REQ_LEN);
    localparam int REQ_DATA  = 6;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] REG_ADDR_HI       = 8'h00;
    localparam logic [7:0] REG_ADDR_LO       = 8'h48;
    localparam logic [7:0] REG_COUNT_HI      = 8'h00;
    localparam logic [7:0] REG_COUNT_LO      = 8'h06;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] DEVICE_ID_RESET = 8'h01;

    // Item codes
    localparam logic CMD_REQUEST  = 1'b0;
    localparam logic CMD_RX_BYTE  = 1'b1;
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RECORD  = 1'b1;

    // Job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_in_item;

    typedef struct packed {
        logic             out_kind;
        logic [7:0]       tx_byte;
        logic             last;
        logic [31:0]      voltage;
        logic [31:0]      current;
        logic [31:0]      power;
        logic [31:0]      energy;
        logic [31:0]      pwr_factor;
        logic [31:0]      co2;
        logic             id_match;
        logic             crc_match;
        logic [LEN_W-1:0] frame_length;
    } t_out_item;

    // One queued job: a whole request frame or one finished record
    typedef struct packed {
        logic                            kind;
        logic [NUM_WORDS-1:0][31:0]      words;
        logic                            id_match;
        logic                            crc_match;
        logic [LEN_W-1:0]                frame_length;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // CRC-16, reflected poly, one byte
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/modbus_meter_frame_engine.sv -----
// ============================================================================
// modbus_meter_frame_engine : RTU read-holding-registers request/response engine
// Builds 8-byte read requests and parses meter response frames into records.
// ============================================================================
// Usage
//   Input channel (i_in_valid / o_in_stall, item i_in_item): cmd = request
//   queues one 8-byte read frame; cmd = rx byte feeds one response byte,
//   rx_last closing the frame. Taken when valid is high and stall is low.
//   Output channel (o_out_valid / i_out_stall, item o_out_item): request
//   bytes (out_kind 0, last on byte eight) or one record per response frame.
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): device id, reset
//   value 1. Ready is always high; write only while the block is idle.
// Timing
//   Response bytes are taken one per cycle while the queue has room, CRC
//   byte update in the same cycle. A record is queued as its last byte is
//   taken and offered at the queue head. A request is offered there as 8
//   items, one per cycle while the output is not stalled. A 4-entry job
//   queue sits between intake and output; input stalls only while it is full.
// Reset
//   Synchronous, active low: CRC to FFFF, count, byte store and held words
//   cleared, queue emptied, device id back to 1. An output stall just holds
//   the head item; intake carries on until the queue fills.
// ============================================================================
`default_nettype none

module modbus_meter_frame_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire mmfe_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output mmfe_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall,
    input  wire logic                i_cfg_valid,
    input  wire logic [7:0]          i_cfg_data,
    output logic                     o_cfg_ready
);

    logic [7:0]          r_device_id;
    logic                w_in_accept;
    logic                w_push;
    logic                w_pop;
    mmfe_pkg::t_job      w_job;
    mmfe_pkg::t_job      w_head;
    mmfe_pkg::t_q_status w_q_status;

    // Config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= mmfe_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_id <= i_cfg_data;
        end
    end

    // Intake stalls only on a full queue
    assign o_in_stall  = w_q_status.full;
    assign w_in_accept = i_in_valid && !o_in_stall;

    mmfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_item      (i_in_item),
        .i_device_id (r_device_id),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    mmfe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    mmfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_empty   (w_q_status.empty),
        .i_device_id (r_device_id),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_pop       (w_pop)
    );

    // Checks

    // No job may be pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("job pushed into full queue");

    // A job leaves the queue only when its final item is taken
    a_pop_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (o_out_valid && !i_out_stall && o_out_item.last))
        else $error("job popped before its final item");

    // Every taken record retires its job
    a_record_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_out_item.out_kind == mmfe_pkg::KIND_RECORD))
        |-> w_pop)
        else $error("record taken without retiring its job");

    // Queue empties only by popping
    a_empty_by_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(w_q_status.empty)) |-> $past(w_pop))
        else $error("queue emptied without a pop");

endmodule

`default_nettype wire

// ----- rtl/core/mmfe_front.sv -----
// ============================================================================
// mmfe_front : item intake and response assembly
// Runs the receive CRC, byte store and length count per response byte and
// queues a request job or a finished record.
// ============================================================================
`default_nettype none

module mmfe_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire mmfe_pkg::t_in_item i_item,
    input  wire logic [7:0]         i_device_id,
    output logic                    o_push,
    output mmfe_pkg::t_job          o_job
);

    logic [15:0]                        r_crc, n_crc;
    logic [mmfe_pkg::CNT_W-1:0]         r_count, n_count;
    logic [1:0][7:0]                    r_tail, n_tail;
    logic [7:0]                         r_first, n_first;
    logic [mmfe_pkg::PAY_BYTES-1:0][7:0] r_pay, n_pay;
    logic [mmfe_pkg::NUM_WORDS-1:0][31:0] r_words, n_words;

    logic rx_take;
    logic rx_store;
    logic rx_end;
    logic id_ok;
    logic crc_ok;
    logic [mmfe_pkg::NUM_WORDS-1:0][31:0] load_words;

    assign rx_take  = i_accept && (i_item.cmd == mmfe_pkg::CMD_RX_BYTE);
    assign rx_store = rx_take && (r_count < mmfe_pkg::CNT_W'(mmfe_pkg::MAX_FRAME));
    assign rx_end   = rx_take && i_item.rx_last;

    always_comb begin
        n_crc   = r_crc;
        n_tail  = r_tail;
        n_first = r_first;
        n_pay   = r_pay;
        n_count = r_count;
        if (rx_store) begin
            if (r_count >= mmfe_pkg::CNT_W'(2)) begin
                n_crc = mmfe_pkg::crc_byte(r_crc, r_tail[0]);
            end
            n_tail[0] = r_tail[1];
            n_tail[1] = i_item.rx_byte;
            if (r_count == '0) begin
                n_first = i_item.rx_byte;
            end
            for (int i = 0; i < mmfe_pkg::PAY_BYTES; i++) begin
                if (r_count == mmfe_pkg::CNT_W'(i + mmfe_pkg::PAY_FIRST)) begin
                    n_pay[i] = i_item.rx_byte;
                end
            end
            n_count = r_count + 1'b1;
        end
    end

    // Big-endian words from the updated store
    always_comb begin
        for (int k = 0; k < mmfe_pkg::NUM_WORDS; k++) begin
            load_words[k] = {n_pay[4*k], n_pay[4*k+1], n_pay[4*k+2], n_pay[4*k+3]};
        end
    end

    assign id_ok   = (n_first == i_device_id);
    assign crc_ok  = (n_count >= mmfe_pkg::CNT_W'(2))
                  && (n_tail[0] == n_crc[7:0]) && (n_tail[1] == n_crc[15:8]);
    assign n_words = (rx_end && id_ok) ? load_words : r_words;

    always_comb begin
        o_job = '0;
        if (rx_end) begin
            o_job.kind         = mmfe_pkg::KIND_RECORD;
            o_job.words        = n_words;
            o_job.id_match     = id_ok;
            o_job.crc_match    = crc_ok;
            o_job.frame_length = mmfe_pkg::LEN_W'(n_count);
        end else begin
            o_job.kind = mmfe_pkg::KIND_REQUEST;
        end
    end

    assign o_push = rx_end || (i_accept && (i_item.cmd == mmfe_pkg::CMD_REQUEST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mmfe_pkg::CRC_INIT;
            r_count <= '0;
            r_tail  <= '0;
            r_first <= '0;
            r_pay   <= '0;
            r_words <= '0;
        end else begin
            r_tail  <= n_tail;
            r_first <= n_first;
            r_pay   <= n_pay;
            r_words <= n_words;
            if (rx_end) begin
                r_crc   <= mmfe_pkg::CRC_INIT;
                r_count <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mmfe_queue.sv -----
// ============================================================================
// mmfe_queue : job queue between front and back end
// Small circular buffer of jobs; head is read straight from storage.
// ============================================================================
`default_nettype none

module mmfe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mmfe_pkg::t_job i_job,
    input  wire logic           i_pop,
    output mmfe_pkg::t_job      o_head,
    output mmfe_pkg::t_q_status o_status
);

    mmfe_pkg::t_job               r_mem [mmfe_pkg::QUEUE_DEPTH];
    logic [mmfe_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [mmfe_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [mmfe_pkg::QCNT_W-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_cnt == mmfe_pkg::QCNT_W'(mmfe_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == mmfe_pkg::QPTR_W'(mmfe_pkg::QUEUE_DEPTH - 1))
                    ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == mmfe_pkg::QPTR_W'(mmfe_pkg::QUEUE_DEPTH - 1))
                    ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mmfe_back.sv -----
// ============================================================================
// mmfe_back : result sequencer
// Plays a request job out as eight frame bytes with a running CRC, or a
// record job as a single record item.
// ============================================================================
`default_nettype none

module mmfe_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mmfe_pkg::t_job      i_head,
    input  wire logic                i_q_empty,
    input  wire logic [7:0]          i_device_id,
    input  wire logic                i_out_stall,
    output logic                     o_out_valid,
    output mmfe_pkg::t_out_item      o_out_item,
    output logic                     o_pop
);

    logic [mmfe_pkg::IDX_W-1:0] r_idx;
    logic [15:0]                r_crc;
    logic [7:0]                 req_byte;
    logic                       out_take;
    logic                       idx_last;

    assign o_out_valid = !i_q_empty;
    assign out_take    = o_out_valid && !i_out_stall;
    assign idx_last    = (r_idx == mmfe_pkg::IDX_W'(mmfe_pkg::REQ_LEN - 1));

    always_comb begin
        unique case (r_idx)
            3'd0:    req_byte = i_device_id;
            3'd1:    req_byte = mmfe_pkg::FUNC_READ_HOLDING;
            3'd2:    req_byte = mmfe_pkg::REG_ADDR_HI;
            3'd3:    req_byte = mmfe_pkg::REG_ADDR_LO;
            3'd4:    req_byte = mmfe_pkg::REG_COUNT_HI;
            3'd5:    req_byte = mmfe_pkg::REG_COUNT_LO;
            3'd6:    req_byte = r_crc[7:0];
            3'd7:    req_byte = r_crc[15:8];
            default: req_byte = '0;
        endcase
    end

    always_comb begin
        o_out_item = '0;
        if (i_head.kind == mmfe_pkg::KIND_RECORD) begin
            o_out_item.out_kind     = mmfe_pkg::KIND_RECORD;
            o_out_item.last         = 1'b1;
            o_out_item.voltage      = i_head.words[0];
            o_out_item.current      = i_head.words[1];
            o_out_item.power        = i_head.words[2];
            o_out_item.energy       = i_head.words[3];
            o_out_item.pwr_factor   = i_head.words[4];
            o_out_item.co2          = i_head.words[5];
            o_out_item.id_match     = i_head.id_match;
            o_out_item.crc_match    = i_head.crc_match;
            o_out_item.frame_length = i_head.frame_length;
        end else begin
            o_out_item.out_kind = mmfe_pkg::KIND_REQUEST;
            o_out_item.tx_byte  = req_byte;
            o_out_item.last     = idx_last;
        end
    end

    assign o_pop = out_take && ((i_head.kind == mmfe_pkg::KIND_RECORD) || idx_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= mmfe_pkg::CRC_INIT;
        end else if (out_take && (i_head.kind == mmfe_pkg::KIND_REQUEST)) begin
            if (idx_last) begin
                r_idx <= '0;
                r_crc <= mmfe_pkg::CRC_INIT;
            end else begin
                r_idx <= r_idx + 1'b1;
                if (r_idx < mmfe_pkg::IDX_W'(mmfe_pkg::REQ_DATA)) begin
                    r_crc <= mmfe_pkg::crc_byte(r_crc, req_byte);
                end
            end
        end
    end

endmodule

`default_nettype wire
